@@ design/sorted_max_priority_queue_defines.svh @@
// Assertion macros used by the priority queue top level.
`ifndef SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check on clk, switched off while rst_n is low.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(label, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ design/spq_pkg.sv @@
// Types and codes of the sorted max-priority queue.
`default_nettype none
package spq_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] item_data;
    logic signed [31:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [31:0]   head_data;
    logic signed [31:0]   head_priority;
    logic                 is_empty;
    logic [COUNT_W-1:0]   entry_count;
  } spq_out_t;

  // One stored slot.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } spq_entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic               ins;
    logic               ext;
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } spq_cmd_t;

endpackage
`default_nettype wire

@@ design/spq_cell.sv @@
// One slot of the sorted store with its compare and shift logic.
`default_nettype none
module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spq_pkg::spq_cmd_t  cmd,
  input  wire spq_pkg::spq_entry_t left_ent,
  input  wire logic               left_gt,
  input  wire spq_pkg::spq_entry_t right_ent,
  output spq_pkg::spq_entry_t     ent,
  output logic                    gt
);
  import spq_pkg::*;

  logic               valid_r, valid_nxt;
  logic signed [31:0] data_r, data_nxt;
  logic signed [31:0] prio_r, prio_nxt;

  // Empty slot or strictly lower priority: the new beat goes at or before here.
  assign gt = !valid_r || (prio_r < cmd.prio);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    prio_nxt  = prio_r;
    if (cmd.ins && gt) begin
      if (left_gt) begin
        valid_nxt = left_ent.valid;
        data_nxt  = left_ent.data;
        prio_nxt  = left_ent.prio;
      end else begin
        valid_nxt = 1'b1;
        data_nxt  = cmd.data;
        prio_nxt  = cmd.prio;
      end
    end else if (cmd.ext) begin
      valid_nxt = right_ent.valid;
      data_nxt  = right_ent.data;
      prio_nxt  = right_ent.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign ent = '{valid: valid_r, data: data_r, prio: prio_r};

endmodule
`default_nettype wire

@@ design/sorted_max_priority_queue.sv @@
// Top level of the bounded max-priority queue built as a chain of cells.
//
// Usage:
//   Input: drive in_item (opcode, item_data, item_priority) and raise start.
//   A beat is taken at each rising edge with start high and busy low.
//   Opcodes: insert, extract maximum, peek maximum; code 3 does nothing.
//   Output: one result beat per input beat, on out_item for exactly one
//   cycle with out_valid high, in the cycle after the input beat is taken.
//   The receiver cannot stall, so results are never held back.
// Throughput: one operation per clock while busy is low. Every cell
//   compares its priority with the incoming one and shifts in parallel, so the
//   rate is set by one 32-bit signed compare plus a 4-way select per cell.
// Reset (rst_n low, synchronous): all cells invalid, count zero; busy is
//   high during reset and in the cycle after it.
// Ordering: equal priorities leave in arrival order. Full inserts return
//   status full; extract or peek on an empty queue return status empty.
`default_nettype none
`include "sorted_max_priority_queue_defines.svh"
module sorted_max_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire spq_pkg::spq_in_t in_item,
  output logic                  out_valid,
  output spq_pkg::spq_out_t     out_item
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

  logic          busy_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  spq_out_t      out_item_r, out_item_nxt;

  logic          accept;
  logic          is_full, is_empty_now;
  logic          do_ins, do_ext;
  spq_cmd_t      cmd;

  // Chain wiring: each cell sees its neighbours' slots and its left neighbour's insert flag.
  spq_entry_t    ent      [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] valid_vec;
  logic [CW+COUNT_W-1:0] count_ext;

  assign accept       = start && !busy_r;
  assign is_full      = (count_r >= CAP_W);
  assign is_empty_now = (count_r == '0);
  assign do_ins = accept && (in_item.opcode == OP_INSERT) && !is_full;
  assign do_ext = accept && (in_item.opcode == OP_EXTRACT) && !is_empty_now;

  assign cmd = '{ins: do_ins, ext: do_ext,
                 data: in_item.item_data, prio: in_item.item_priority};

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      spq_entry_t left_e, right_e;
      logic       left_g;
      if (i == 0) begin : g_first
        assign left_e = '0;
        assign left_g = 1'b0;
      end else begin : g_mid
        assign left_e = ent[i-1];
        assign left_g = gt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = ent[i+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .left_ent  (left_e),
        .left_gt   (left_g),
        .right_ent (right_e),
        .ent       (ent[i]),
        .gt        (gt[i])
      );
      assign valid_vec[i] = ent[i].valid;
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_ext) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Result beat: head of the chain is cell 0.
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};
  always_comb begin
    out_item_nxt.status        = ST_DONE;
    out_item_nxt.head_data     = '0;
    out_item_nxt.head_priority = '0;
    case (in_item.opcode)
      OP_INSERT: begin
        if (is_full) begin
          out_item_nxt.status = ST_FULL;
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (is_empty_now) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          out_item_nxt.head_data     = ent[0].data;
          out_item_nxt.head_priority = ent[0].prio;
        end
      end
      default: begin
      end
    endcase
    out_item_nxt.is_empty    = (count_nxt == '0);
    out_item_nxt.entry_count = count_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Count never exceeds the store.
  `SPQ_ASSERT(a_count_range, (count_r <= CAP_W), "count above capacity")
  // The number of valid slots equals the count.
  `SPQ_ASSERT(a_valid_count, ($countones(valid_vec) == int'(count_r)), "valid slots != count")
  // Head slot holds an entry exactly when the queue is not empty.
  `SPQ_ASSERT(a_head_valid, (ent[0].valid == (count_r != '0)), "head valid mismatch")
  // One result beat follows every accepted input beat.
  `SPQ_ASSERT(a_one_result, (accept |=> out_valid_r), "result beat missing")
  // Insert and extract never act together.
  `SPQ_ASSERT_ALWAYS(a_cmd_excl, (!(do_ins && do_ext)), "insert and extract together")

endmodule
`default_nettype wire
